// ===== rtl/core/uihb_pkg.sv =====
// uihb_pkg: shared types and constants of the udp/ipv4 header builder
`default_nettype none
package uihb_pkg;

  // default payload limit and fixed field widths
  localparam int MaxPayloadDefault = 4044;
  localparam int CountW            = 16;
  localparam int LenW              = 12;
  localparam int CfgIndexW         = 3;
  localparam int CfgDataW          = 48;
  localparam int NumWords          = 13;
  localparam int WordIdxW          = 4;
  localparam int QueueDepth        = 2;
  localparam int QueuePtrW         = 1;
  localparam int QueueLevelW       = 2;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegSourceMac  = 3'd0;
  localparam logic [CfgIndexW-1:0] RegDestMac    = 3'd1;
  localparam logic [CfgIndexW-1:0] RegSourceIpv4 = 3'd2;
  localparam logic [CfgIndexW-1:0] RegDestIpv4   = 3'd3;
  localparam logic [CfgIndexW-1:0] RegSourcePort = 3'd4;
  localparam logic [CfgIndexW-1:0] RegDestPort   = 3'd5;

  // protocol constants
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  IpVerIhl      = 8'h45;
  localparam logic [15:0] IpFlagsDf     = 16'h4000;
  localparam logic [7:0]  IpTtl         = 8'd64;
  localparam logic [7:0]  IpProtoUdp    = 8'h11;
  localparam logic [15:0] UdpHdrLen     = 16'd8;
  localparam logic [15:0] IpUdpHdrLen   = 16'd28;
  // 0x4500 + 0x4000 + 0x4011 folded into one constant
  localparam logic [15:0] IpFixedSum    = 16'hC511;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [31:0] source_ipv4;
    logic [31:0] dest_ipv4;
    logic [15:0] source_udp_port;
    logic [15:0] dest_udp_port;
  } cfg_t;

  // one closed frame handed from front to back
  typedef struct packed {
    logic [15:0]       sum;
    logic [CountW-1:0] count;
    logic              overlong;
  } desc_t;

  // queue status seen by both sides
  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QueueLevelW-1:0] level;
  } qstat_t;

endpackage
`default_nettype wire

// ===== rtl/core/uihb_intf.sv =====
// uihb_intf: stream interfaces for payload bytes and header words
`default_nettype none
interface uihb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       byte_present;
  logic       frame_end;

  modport source (output valid, payload_byte, byte_present, frame_end, input ready);
  modport sink   (input valid, payload_byte, byte_present, frame_end, output ready);
endinterface

interface uihb_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic        word_last;
  logic [11:0] payload_length;
  logic        payload_overlong;

  modport source (output valid, header_word, word_last, payload_length, payload_overlong,
                  input ready);
  modport sink   (input valid, header_word, word_last, payload_length, payload_overlong,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/uihb_front.sv =====
// uihb_front: payload byte intake, running checksum and frame close
`default_nettype none
module uihb_front #(
  parameter int MaxPayload = uihb_pkg::MaxPayloadDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  uihb_byte_if.sink           bytes,
  input  wire uihb_pkg::qstat_t qs,
  output uihb_pkg::desc_t     push_desc,
  output logic                push
);
  import uihb_pkg::*;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxPayload);

  logic [15:0]       payload_sum;
  logic [CountW-1:0] byte_count;
  logic              overlong_seen;

  logic              xfer;
  logic              add_byte;
  logic [15:0]       weighted;
  logic [16:0]       raw_sum;
  logic [15:0]       sum_next;
  logic [CountW-1:0] count_next;
  logic              overlong_next;

  // a frame end needs a free queue slot
  assign bytes.ready = !qs.full;
  assign xfer        = bytes.valid && bytes.ready;

  // even offsets weigh as high byte, odd as low byte
  always_comb begin
    add_byte = bytes.byte_present && (byte_count < MaxCount);
    weighted = byte_count[0] ? {8'h00, bytes.payload_byte} : {bytes.payload_byte, 8'h00};
    raw_sum  = {1'b0, payload_sum} + {1'b0, weighted};
    if (add_byte) begin
      sum_next   = raw_sum[15:0] + {15'd0, raw_sum[16]};
      count_next = byte_count + 1'b1;
    end else begin
      sum_next   = payload_sum;
      count_next = byte_count;
    end
    overlong_next = overlong_seen || (bytes.byte_present && !add_byte);
  end

  // closed frame descriptor
  assign push      = xfer && bytes.frame_end;
  assign push_desc = '{sum: sum_next, count: count_next, overlong: overlong_next};

  // frame state, cleared when a frame closes
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_sum   <= '0;
      byte_count    <= '0;
      overlong_seen <= 1'b0;
    end else if (xfer) begin
      if (bytes.frame_end) begin
        payload_sum   <= '0;
        byte_count    <= '0;
        overlong_seen <= 1'b0;
      end else begin
        payload_sum   <= sum_next;
        byte_count    <= count_next;
        overlong_seen <= overlong_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/uihb_queue.sv =====
// uihb_queue: two-entry descriptor queue between front and back
`default_nettype none
module uihb_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire uihb_pkg::desc_t push_desc,
  input  wire logic            pop,
  output uihb_pkg::desc_t      head,
  output uihb_pkg::qstat_t     qs
);
  import uihb_pkg::*;

  desc_t                  entries [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueueLevelW-1:0] level;

  assign head     = entries[rd_ptr];
  assign qs.full  = (level == QueueLevelW'(QueueDepth));
  assign qs.empty = (level == '0);
  assign qs.level = level;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/uihb_back.sv =====
// uihb_back: checksum finish and header word sequencer
`default_nettype none
module uihb_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire uihb_pkg::cfg_t   cfg,
  input  wire uihb_pkg::desc_t  head,
  input  wire uihb_pkg::qstat_t qs,
  output logic                  pop,
  uihb_word_if.source           words
);
  import uihb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CALC,
    ST_FOLD,
    ST_EMIT
  } state_t;

  state_t              state;
  desc_t               frame;
  logic [17:0]         addr_sum;
  logic [17:0]         misc_sum;
  logic [19:0]         ip_raw;
  logic [19:0]         udp_raw;
  logic [15:0]         ip_csum;
  logic [15:0]         udp_csum;
  logic [WordIdxW-1:0] word_idx;

  logic            out_valid;
  logic [31:0]     out_word;
  logic            out_last;
  logic [LenW-1:0] out_len;
  logic            out_over;

  logic [15:0] ip_len;
  logic [15:0] udp_len;
  logic [16:0] ip_fold1;
  logic [16:0] udp_fold1;
  logic [15:0] ip_fold2;
  logic [15:0] udp_fold2;
  logic [31:0] word_sel;
  logic        load;

  // length fields, truncated to 16 bits
  assign ip_len  = IpUdpHdrLen + frame.count;
  assign udp_len = UdpHdrLen + frame.count;

  // end-around fold of the raw sums
  always_comb begin
    ip_fold1  = {1'b0, ip_raw[15:0]} + {13'd0, ip_raw[19:16]};
    udp_fold1 = {1'b0, udp_raw[15:0]} + {13'd0, udp_raw[19:16]};
    ip_fold2  = ip_fold1[15:0] + {15'd0, ip_fold1[16]};
    udp_fold2 = udp_fold1[15:0] + {15'd0, udp_fold1[16]};
  end

  // header word select
  always_comb begin
    case (word_idx)
      4'd2:    word_sel = {16'h0000, cfg.dest_mac[47:32]};
      4'd3:    word_sel = cfg.dest_mac[31:0];
      4'd4:    word_sel = cfg.source_mac[47:16];
      4'd5:    word_sel = {cfg.source_mac[15:0], EtherTypeIpv4};
      4'd6:    word_sel = {IpVerIhl, 8'h00, ip_len};
      4'd7:    word_sel = {16'h0000, IpFlagsDf};
      4'd8:    word_sel = {IpTtl, IpProtoUdp, ip_csum};
      4'd9:    word_sel = cfg.source_ipv4;
      4'd10:   word_sel = cfg.dest_ipv4;
      4'd11:   word_sel = {cfg.source_udp_port, cfg.dest_udp_port};
      4'd12:   word_sel = {udp_len, udp_csum};
      default: word_sel = 32'h0000_0000;
    endcase
  end

  assign pop  = (state == ST_IDLE) && !qs.empty;
  assign load = (state == ST_EMIT) && (!out_valid || words.ready);

  assign words.valid            = out_valid;
  assign words.header_word      = out_word;
  assign words.word_last        = out_last;
  assign words.payload_length   = out_len;
  assign words.payload_overlong = out_over;

  // sequencer, checksum pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      word_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            frame <= head;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          addr_sum <= {2'b00, cfg.source_ipv4[31:16]} + {2'b00, cfg.source_ipv4[15:0]}
                    + {2'b00, cfg.dest_ipv4[31:16]} + {2'b00, cfg.dest_ipv4[15:0]};
          misc_sum <= {2'b00, frame.sum} + {2'b00, cfg.source_udp_port}
                    + {2'b00, cfg.dest_udp_port} + {10'd0, IpProtoUdp};
          state    <= ST_CALC;
        end
        ST_CALC: begin
          ip_raw  <= {2'b00, addr_sum} + {4'd0, ip_len} + {4'd0, IpFixedSum};
          udp_raw <= {2'b00, addr_sum} + {2'b00, misc_sum} + {3'd0, udp_len, 1'b0};
          state   <= ST_FOLD;
        end
        ST_FOLD: begin
          ip_csum  <= ~ip_fold2;
          udp_csum <= ~udp_fold2;
          word_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            word_idx <= word_idx + 1'b1;
            if (word_idx == WordIdxW'(NumWords - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      // output register, loaded when empty or as its word is taken
      if (load) begin
        out_valid <= 1'b1;
        out_word  <= word_sel;
        out_last  <= (word_idx == WordIdxW'(NumWords - 1));
        out_len   <= frame.count[LenW-1:0];
        out_over  <= frame.overlong;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/udp_ipv4_header_builder_unit.sv =====
// udp_ipv4_header_builder_unit: top level of the udp/ipv4 frame header builder
//
//   channel  dir  handshake        payload
//   bytes    in   valid/ready      payload_byte, byte_present, frame_end
//   words    out  valid/ready      header_word, word_last, payload_length, payload_overlong
//   cfg      in   cfg_we           cfg_index, cfg_data (no read-back)
//
// payload bytes are taken one per cycle while the queue is not full; the running sum is one 17-bit add and fold
// a frame end hands a descriptor to a two-entry queue; bytes stall only when it is full
// the back side works out the checksums in its SUM, CALC and FOLD states, then emits 13 words
// at one per cycle unless the output stalls, and takes no new frame until its last word is loaded
// words leave through an output register that refills on the cycle it is taken
// rst is synchronous, active high, and clears frame state, queue and configuration
`default_nettype none
module udp_ipv4_header_builder_unit #(
  parameter int MaxPayload = uihb_pkg::MaxPayloadDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  uihb_byte_if.sink                           bytes,
  uihb_word_if.source                         words,
  input  wire logic                           cfg_we,
  input  wire logic [uihb_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [uihb_pkg::CfgDataW-1:0]  cfg_data
);
  import uihb_pkg::*;

  cfg_t   cfg;
  desc_t  push_desc;
  desc_t  head;
  qstat_t qs;
  logic   push;
  logic   pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSourceMac:  cfg.source_mac      <= cfg_data;
        RegDestMac:    cfg.dest_mac        <= cfg_data;
        RegSourceIpv4: cfg.source_ipv4     <= cfg_data[31:0];
        RegDestIpv4:   cfg.dest_ipv4       <= cfg_data[31:0];
        RegSourcePort: cfg.source_udp_port <= cfg_data[15:0];
        RegDestPort:   cfg.dest_udp_port   <= cfg_data[15:0];
        default:       cfg                 <= cfg;
      endcase
    end
  end

  uihb_front #(
    .MaxPayload (MaxPayload)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .qs        (qs),
    .push_desc (push_desc),
    .push      (push)
  );

  uihb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  uihb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .qs    (qs),
    .pop   (pop),
    .words (words)
  );

  // a frame close never lands on a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !qs.full)
    else $error("frame descriptor pushed into full queue");

  // queue fill level stays within its depth
  assert property (@(posedge clk) disable iff (rst) qs.level <= QueueLevelW'(QueueDepth))
    else $error("queue level beyond depth");

  // the back side never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !qs.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sim/udp_ipv4_header_builder_unit_test.sv =====
// testbench for the udp/ipv4 header builder: shadow header model with checked word stream
`timescale 1ns / 100ps
module udp_ipv4_header_builder_unit_test;

  // payload limit and word count as built into the block
  localparam int PayloadLimit  = 4044;
  localparam int WordsPerFrame = 13;
  localparam int CycleLimit    = 400000;
  localparam int DrainCycles   = 40;
  localparam int HoldCycles    = 400;
  localparam int RandomItems   = 320;

  // header field values of a udp/ipv4 frame
  localparam logic [15:0] EthTypeIp = 16'h0800;
  localparam logic [7:0]  VerIhl    = 8'h45;
  localparam logic [15:0] FlagsDf   = 16'h4000;
  localparam logic [7:0]  TtlValue  = 8'd64;
  localparam logic [7:0]  ProtoUdp  = 8'h11;

  // register indexes that decode to no register
  localparam logic [uihb_pkg::CfgIndexW-1:0] RegSpareLo = 3'd6;
  localparam logic [uihb_pkg::CfgIndexW-1:0] RegSpareHi = 3'd7;

  typedef enum logic [1:0] {SinkAlways, SinkRandom, SinkPattern} sink_style_e;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic [11:0] len;
    logic        dropped;
  } hdr_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [uihb_pkg::CfgIndexW-1:0] cfg_index;
  logic [uihb_pkg::CfgDataW-1:0]  cfg_data;

  uihb_byte_if byte_ch ();
  uihb_word_if word_ch ();

  udp_ipv4_header_builder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .bytes     (byte_ch),
    .words     (word_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of configuration and running frame state
  uihb_pkg::cfg_t cfg_shadow;
  logic [31:0] run_sum;
  logic [15:0] run_count;
  logic        run_dropped;
  hdr_word_t   hdr_words_expected[$];

  // traffic shaping and bookkeeping
  bit          src_gaps;
  int          burst_left;
  sink_style_e sink_style;
  int          hold_requests;
  int          items_sent;
  int          frames_closed;
  int          dropped_frames;
  int          words_checked;
  int          mismatch_count;
  int          cycle_count;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // end-around carry add
  function automatic logic [31:0] ones_add(input logic [31:0] acc, input logic [15:0] v);
    logic [31:0] s;
    s = acc + {16'h0, v};
    while (s[31:16] != 16'h0) s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    return s;
  endfunction

  // pseudo-header, udp header and payload sum, folded to 16 bits
  function automatic logic [31:0] udp_sum(input logic [31:0] data_sum, input logic [15:0] udp_len);
    logic [31:0] s;
    s = data_sum;
    s = ones_add(s, cfg_shadow.source_ipv4[31:16]);
    s = ones_add(s, cfg_shadow.source_ipv4[15:0]);
    s = ones_add(s, cfg_shadow.dest_ipv4[31:16]);
    s = ones_add(s, cfg_shadow.dest_ipv4[15:0]);
    s = ones_add(s, {8'h00, ProtoUdp});
    s = ones_add(s, udp_len);
    s = ones_add(s, cfg_shadow.source_udp_port);
    s = ones_add(s, cfg_shadow.dest_udp_port);
    s = ones_add(s, udp_len);
    return s;
  endfunction

  // build the 52-byte prefix of a closed frame and queue its thirteen words
  function automatic void predict_frame();
    logic [15:0]  udp_len;
    logic [15:0]  ip_len;
    logic [31:0]  s;
    logic [15:0]  ip_csum;
    logic [15:0]  udp_csum;
    logic [415:0] hdr;
    hdr_word_t    w;
    udp_len = 16'd8 + run_count;
    ip_len  = 16'd28 + run_count;
    s = 32'h0;
    s = ones_add(s, {VerIhl, 8'h00});
    s = ones_add(s, ip_len);
    s = ones_add(s, FlagsDf);
    s = ones_add(s, {TtlValue, ProtoUdp});
    s = ones_add(s, cfg_shadow.source_ipv4[31:16]);
    s = ones_add(s, cfg_shadow.source_ipv4[15:0]);
    s = ones_add(s, cfg_shadow.dest_ipv4[31:16]);
    s = ones_add(s, cfg_shadow.dest_ipv4[15:0]);
    ip_csum = ~s[15:0];
    s = udp_sum(run_sum, udp_len);
    udp_csum = ~s[15:0];
    hdr = {80'h0, cfg_shadow.dest_mac, cfg_shadow.source_mac, EthTypeIp,
           VerIhl, 8'h00, ip_len, 16'h0000, FlagsDf, TtlValue, ProtoUdp, ip_csum,
           cfg_shadow.source_ipv4, cfg_shadow.dest_ipv4,
           cfg_shadow.source_udp_port, cfg_shadow.dest_udp_port, udp_len, udp_csum};
    for (int k = 0; k < WordsPerFrame; k++) begin
      w.word    = hdr[415 - 32*k -: 32];
      w.last    = (k == WordsPerFrame - 1);
      w.len     = run_count[11:0];
      w.dropped = run_dropped;
      hdr_words_expected.push_back(w);
    end
    frames_closed++;
    if (run_dropped) dropped_frames++;
    run_sum     = 32'h0;
    run_count   = 16'h0;
    run_dropped = 1'b0;
  endfunction

  // advance the shadow by one accepted item
  function automatic void predict_transfer(input logic [7:0] b, input logic present,
                                           input logic fend);
    if (present) begin
      if (run_count < PayloadLimit) begin
        run_sum   = ones_add(run_sum, run_count[0] ? {8'h0, b} : {b, 8'h00});
        run_count = run_count + 16'd1;
      end else begin
        run_dropped = 1'b1;
      end
    end
    if (fend) predict_frame();
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // offer one item and wait for its transfer; bursts with random gaps in between when src_gaps is set
  task automatic send_item(input logic [7:0] b, input logic present, input logic fend);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (src_gaps) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_ch.valid        <= 1'b1;
    byte_ch.payload_byte <= b;
    byte_ch.byte_present <= present;
    byte_ch.frame_end    <= fend;
    @(negedge clk);
    while (!byte_ch.ready) @(negedge clk);
    @(posedge clk);
    predict_transfer(b, present, fend);
    if (present || fend) items_sent++;
  endtask

  // stop offering and let every expected word come out
  task automatic finish_phase();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    while (hdr_words_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [uihb_pkg::CfgIndexW-1:0] idx, input logic [47:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      uihb_pkg::RegSourceMac:  cfg_shadow.source_mac      = data;
      uihb_pkg::RegDestMac:    cfg_shadow.dest_mac        = data;
      uihb_pkg::RegSourceIpv4: cfg_shadow.source_ipv4     = data[31:0];
      uihb_pkg::RegDestIpv4:   cfg_shadow.dest_ipv4       = data[31:0];
      uihb_pkg::RegSourcePort: cfg_shadow.source_udp_port = data[15:0];
      uihb_pkg::RegDestPort:   cfg_shadow.dest_udp_port   = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [47:0] smac, input logic [47:0] dmac,
                           input logic [31:0] sip, input logic [31:0] dip,
                           input logic [15:0] sport, input logic [15:0] dport);
    write_reg(uihb_pkg::RegSourceMac, smac);
    write_reg(uihb_pkg::RegDestMac, dmac);
    write_reg(uihb_pkg::RegSourceIpv4, {16'h0, sip});
    write_reg(uihb_pkg::RegDestIpv4, {16'h0, dip});
    write_reg(uihb_pkg::RegSourcePort, {32'h0, sport});
    write_reg(uihb_pkg::RegDestPort, {32'h0, dport});
  endtask

  // mostly well-formed frames, some absent-byte noise, a few longer payloads
  task automatic send_random_frame();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n = (kind == 0) ? 0 : (kind < 8) ? $urandom_range(1, 16) : $urandom_range(17, 90);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // reset configuration: empty frame, single byte, absent bytes inside a frame
  task automatic test_reset_defaults();
    src_gaps   = 1'b0;
    sink_style = SinkAlways;
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5A, 1'b1, 1'b1);
    finish_phase();
  endtask

  // all-ones and alternating register values; spare indexes must change nothing
  task automatic test_config_extremes();
    write_all('1, '1, '1, '1, '1, '1);
    write_reg(RegSpareLo, 48'h0);
    write_reg(RegSpareHi, 48'h0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    finish_phase();
    write_all(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'h8000_0001, 32'h7FFF_FFFE,
              16'h8000, 16'h0001);
    write_reg(RegSpareLo, '1);
    write_reg(RegSpareHi, '1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);
    finish_phase();
  endtask

  // two payload bytes chosen so the udp checksum comes out as zero
  task automatic test_zero_checksum();
    logic [31:0] s0;
    logic [15:0] w;
    write_all(rand48(), rand48(), $urandom, $urandom, 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    s0 = udp_sum(32'h0, 16'd10);
    w  = 16'hFFFF - s0[15:0];
    send_item(w[15:8], 1'b1, 1'b0);
    send_item(w[7:0], 1'b1, 1'b1);
    finish_phase();
  endtask

  // payload filled to the limit and past it with dropped bytes, then a short frame
  task automatic test_length_limit();
    src_gaps   = 1'b0;
    sink_style = SinkRandom;
    for (int i = 0; i < PayloadLimit + 3; i++) begin
      if (i == PayloadLimit + 1) send_item(8'h00, 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    send_item(8'h3C, 1'b1, 1'b1);
    finish_phase();
  endtask

  // random frames across several configurations and traffic shapes
  task automatic test_random_frames();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1)
        write_all('1, '1, '1, '1, '1, '1);
      else
        write_all(rand48(), rand48(), $urandom, $urandom, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
      src_gaps   = (phase != 2);
      sink_style = (phase == 2) ? SinkAlways : (phase == 1) ? SinkPattern : SinkRandom;
      target = items_sent + RandomItems / 4;
      while (items_sent < target) send_random_frame();
      finish_phase();
    end
  endtask

  // long output hold-off while short frames keep coming, so the input backs up
  task automatic test_output_backpressure();
    src_gaps   = 1'b0;
    sink_style = SinkAlways;
    hold_requests++;
    for (int f = 0; f < 10; f++) begin
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
    finish_phase();
  endtask

  // output ready: per-style stalls, plus a counted hold-off on request
  initial begin
    int          hold_left;
    int          holds_seen;
    logic [6:0]  rot;
    hold_left  = 0;
    holds_seen = 0;
    rot        = 7'b1011001;
    word_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        word_ch.ready <= 1'b0;
      end else begin
        case (sink_style)
          SinkAlways: word_ch.ready <= 1'b1;
          SinkRandom: word_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            rot = {rot[5:0], rot[6]};
            word_ch.ready <= rot[0];
          end
        endcase
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    mismatch_count++;
  endtask

  // compare each word transfer with the oldest expected word
  always @(negedge clk) begin
    hdr_word_t want;
    if (!rst && word_ch.valid && word_ch.ready) begin
      if (hdr_words_expected.size() == 0) begin
        $display("%0t: header word %h with none expected, expected nothing, actual %h",
                 $time, word_ch.header_word, word_ch.header_word);
        mismatch_count++;
      end else begin
        want = hdr_words_expected.pop_front();
        if (word_ch.header_word !== want.word)
          report_field("header_word", want.word, word_ch.header_word);
        if (word_ch.word_last !== want.last)
          report_field("word_last", {31'h0, want.last}, {31'h0, word_ch.word_last});
        if (word_ch.payload_length !== want.len)
          report_field("payload_length", {20'h0, want.len}, {20'h0, word_ch.payload_length});
        if (word_ch.payload_overlong !== want.dropped)
          report_field("payload_overlong", {31'h0, want.dropped},
                       {31'h0, word_ch.payload_overlong});
        words_checked++;
      end
    end
  end

  // run time guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycle_count,
             hdr_words_expected.size());
    $display("Simulation FAILED");
    $finish;
  end

  // test sequence
  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    byte_ch.valid        <= 1'b0;
    byte_ch.payload_byte <= 8'h00;
    byte_ch.byte_present <= 1'b0;
    byte_ch.frame_end    <= 1'b0;
    cfg_shadow     = '0;
    run_sum        = 32'h0;
    run_count      = 16'h0;
    run_dropped    = 1'b0;
    src_gaps       = 1'b0;
    burst_left     = 0;
    sink_style     = SinkAlways;
    hold_requests  = 0;
    items_sent     = 0;
    frames_closed  = 0;
    dropped_frames = 0;
    words_checked  = 0;
    mismatch_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_zero_checksum();
    test_length_limit();
    test_random_frames();
    test_output_backpressure();

    $display("covered %0d frames (%0d with dropped bytes) from %0d payload transfers",
             frames_closed, dropped_frames, items_sent);
    $display("checked %0d header words across reset, extreme and random configurations",
             words_checked);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/uihb_pkg.sv
rtl/core/uihb_intf.sv
rtl/core/uihb_front.sv
rtl/core/uihb_queue.sv
rtl/core/uihb_back.sv
rtl/core/udp_ipv4_header_builder_unit.sv
sim/udp_ipv4_header_builder_unit_test.sv
